// File: src/fat32_cluster_chain_engine_macros.svh
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine assertion macros
// Implication checks on the engine ports, compiled out under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FAT32_CLUSTER_CHAIN_ENGINE_MACROS_SVH
`define FAT32_CLUSTER_CHAIN_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define FCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/fcce_pkg.sv
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine package
// Table geometry, codes, beat payloads and controller/datapath interface.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned SCAN_W      = TBL_AW + 1;

  localparam logic [27:0] EOC_MARK      = 28'hFFFFFF8;
  localparam logic [31:0] EOC_WORD      = 32'h0FFFFFF8;
  localparam logic [27:0] FIRST_CLUSTER = 28'd2;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_NEXT   = 3'd2,
    OP_ALLOC  = 3'd3,
    OP_EXTEND = 3'd4,
    OP_FREE   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EOC   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    CFG_CLUSTER_COUNT       = 2'd0,
    CFG_SECTORS_PER_CLUSTER = 2'd1,
    CFG_DATA_START_SECTOR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_WORD,
    S_ENTRY_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LINK,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_MUL,
    S_ADD,
    S_DONE
  } state_e;

  typedef enum logic {
    AS_CLUSTER,
    AS_SCAN
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_WORD,
    WD_EOC,
    WD_SCAN,
    WD_ZERO
  } wd_sel_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [27:0] cluster;
    logic [31:0] word;
  } item_t;

  typedef struct packed {
    logic [27:0] result_cluster;
    logic [31:0] read_word;
    logic [31:0] sector_address;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic      latch;
    logic      mem_re;
    logic      mem_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      scan_init;
    logic      scan_inc;
    logic      res_from_entry;
    logic      res_from_scan;
    logic      rword_load;
    logic      stat_we;
    stat_e     stat_val;
    logic      mul_en;
    logic      add_en;
    logic      free_adv;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic clu_in_table;
    logic clu_in_range;
    logic entry_eoc;
    logic entry_free;
    logic scan_in_range;
    logic free_more;
  } sts_t;

  function automatic logic in_range(logic [27:0] c, logic [15:0] count);
    logic [16:0] lim;
    lim = {1'b0, count} + 17'd2;
    return (c >= FIRST_CLUSTER) && (c < {11'b0, lim}) && (c < 28'(TABLE_DEPTH));
  endfunction

endpackage

// File: src/fcce_ctrl.sv
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine controller
// Sequences each operation over the table port, scan and sector unit.
// ----------------------------------------------------------------------------
module fcce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fcce_pkg::sts_t sts_i,
  output fcce_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  fcce_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcce_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcce_pkg::S_IDLE: begin
        if (start_i) state_d = fcce_pkg::S_DISPATCH;
      end
      fcce_pkg::S_DISPATCH: begin
        unique case (sts_i.op)
          fcce_pkg::OP_LOAD:   state_d = fcce_pkg::S_DONE;
          fcce_pkg::OP_READ:
            state_d = sts_i.clu_in_table ? fcce_pkg::S_RD_WORD : fcce_pkg::S_DONE;
          fcce_pkg::OP_NEXT, fcce_pkg::OP_EXTEND:
            state_d = sts_i.clu_in_range ? fcce_pkg::S_ENTRY_CHK : fcce_pkg::S_DONE;
          fcce_pkg::OP_ALLOC:  state_d = fcce_pkg::S_SCAN_RD;
          fcce_pkg::OP_FREE:
            state_d = sts_i.clu_in_range ? fcce_pkg::S_FREE_CHK : fcce_pkg::S_DONE;
          default:             state_d = fcce_pkg::S_DONE;
        endcase
      end
      fcce_pkg::S_RD_WORD: state_d = fcce_pkg::S_DONE;
      fcce_pkg::S_ENTRY_CHK: begin
        if (!sts_i.entry_eoc) begin
          state_d = fcce_pkg::S_MUL;
        end else if (sts_i.op == fcce_pkg::OP_EXTEND) begin
          state_d = fcce_pkg::S_SCAN_RD;
        end else begin
          state_d = fcce_pkg::S_DONE;
        end
      end
      fcce_pkg::S_SCAN_RD: begin
        state_d = sts_i.scan_in_range ? fcce_pkg::S_SCAN_CHK : fcce_pkg::S_DONE;
      end
      fcce_pkg::S_SCAN_CHK: begin
        if (!sts_i.entry_free) begin
          state_d = fcce_pkg::S_SCAN_RD;
        end else if (sts_i.op == fcce_pkg::OP_EXTEND) begin
          state_d = fcce_pkg::S_LINK;
        end else begin
          state_d = fcce_pkg::S_MARK;
        end
      end
      fcce_pkg::S_LINK:     state_d = fcce_pkg::S_MARK;
      fcce_pkg::S_MARK:     state_d = fcce_pkg::S_MUL;
      fcce_pkg::S_FREE_RD:  state_d = fcce_pkg::S_FREE_CHK;
      fcce_pkg::S_FREE_CHK: begin
        state_d = sts_i.free_more ? fcce_pkg::S_FREE_RD : fcce_pkg::S_DONE;
      end
      fcce_pkg::S_MUL:      state_d = fcce_pkg::S_ADD;
      fcce_pkg::S_ADD:      state_d = fcce_pkg::S_DONE;
      fcce_pkg::S_DONE:     state_d = fcce_pkg::S_IDLE;
      default:              state_d = fcce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = fcce_pkg::AS_CLUSTER;
    cmd_o.wd_sel   = fcce_pkg::WD_WORD;
    cmd_o.stat_val = fcce_pkg::ST_OK;
    unique case (state_q)
      fcce_pkg::S_IDLE: cmd_o.latch = start_i;
      fcce_pkg::S_DISPATCH: begin
        unique case (sts_i.op)
          fcce_pkg::OP_LOAD: begin
            cmd_o.mem_we   = sts_i.clu_in_table;
            cmd_o.stat_we  = !sts_i.clu_in_table;
            cmd_o.stat_val = fcce_pkg::ST_RANGE;
          end
          fcce_pkg::OP_READ: begin
            cmd_o.mem_re   = sts_i.clu_in_table;
            cmd_o.stat_we  = !sts_i.clu_in_table;
            cmd_o.stat_val = fcce_pkg::ST_RANGE;
          end
          fcce_pkg::OP_NEXT: begin
            cmd_o.mem_re   = sts_i.clu_in_range;
            cmd_o.stat_we  = !sts_i.clu_in_range;
            cmd_o.stat_val = fcce_pkg::ST_EOC;
          end
          fcce_pkg::OP_ALLOC: cmd_o.scan_init = 1'b1;
          fcce_pkg::OP_EXTEND, fcce_pkg::OP_FREE: begin
            cmd_o.mem_re   = sts_i.clu_in_range;
            cmd_o.stat_we  = !sts_i.clu_in_range;
            cmd_o.stat_val = fcce_pkg::ST_RANGE;
          end
          default: begin
            cmd_o.stat_we  = 1'b1;
            cmd_o.stat_val = fcce_pkg::ST_RANGE;
          end
        endcase
      end
      fcce_pkg::S_RD_WORD: cmd_o.rword_load = 1'b1;
      fcce_pkg::S_ENTRY_CHK: begin
        if (!sts_i.entry_eoc) begin
          cmd_o.res_from_entry = 1'b1;
        end else if (sts_i.op == fcce_pkg::OP_EXTEND) begin
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = fcce_pkg::ST_EOC;
        end
      end
      fcce_pkg::S_SCAN_RD: begin
        cmd_o.addr_sel = fcce_pkg::AS_SCAN;
        cmd_o.mem_re   = sts_i.scan_in_range;
        cmd_o.stat_we  = !sts_i.scan_in_range;
        cmd_o.stat_val = fcce_pkg::ST_FULL;
      end
      fcce_pkg::S_SCAN_CHK: cmd_o.scan_inc = !sts_i.entry_free;
      fcce_pkg::S_LINK: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wd_sel = fcce_pkg::WD_SCAN;
      end
      fcce_pkg::S_MARK: begin
        cmd_o.mem_we        = 1'b1;
        cmd_o.addr_sel      = fcce_pkg::AS_SCAN;
        cmd_o.wd_sel        = fcce_pkg::WD_EOC;
        cmd_o.res_from_scan = 1'b1;
      end
      fcce_pkg::S_FREE_RD: cmd_o.mem_re = 1'b1;
      fcce_pkg::S_FREE_CHK: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wd_sel   = fcce_pkg::WD_ZERO;
        cmd_o.free_adv = sts_i.free_more;
      end
      fcce_pkg::S_MUL: cmd_o.mul_en = 1'b1;
      fcce_pkg::S_ADD: cmd_o.add_en = 1'b1;
      fcce_pkg::S_DONE: ;
      default: ;
    endcase
  end

  assign busy_o = (state_q != fcce_pkg::S_IDLE);
  assign done_o = (state_q == fcce_pkg::S_DONE);

endmodule

// File: src/fcce_datapath.sv
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine datapath
// Allocation table memory, configuration, scan and walk counters, sector unit.
// ----------------------------------------------------------------------------
module fcce_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  fcce_pkg::item_t   item_i,
  input  fcce_pkg::cmd_t    cmd_i,
  output fcce_pkg::sts_t    sts_o,
  output fcce_pkg::result_t result_o
);

  logic [15:0] count_q;
  logic [7:0]  spc_q;
  logic [31:0] dss_q;

  logic [31:0] mem_q [fcce_pkg::TABLE_DEPTH];
  logic [31:0] rdata_q;
  logic [fcce_pkg::TBL_AW-1:0] addr;
  logic [31:0] wdata;

  logic [2:0]  op_q;
  logic [27:0] clu_q;
  logic [31:0] word_q;
  logic [fcce_pkg::SCAN_W-1:0] scan_q;
  logic [fcce_pkg::TBL_AW-1:0] steps_q;
  logic [27:0] res_q;
  logic [31:0] rword_q;
  logic [31:0] prod_q;
  logic [31:0] sect_q;
  fcce_pkg::stat_e stat_q;

  logic [27:0] entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      spc_q   <= 8'd1;
      dss_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (fcce_pkg::cfg_idx_e'(cfg_index_i))
        fcce_pkg::CFG_CLUSTER_COUNT:       count_q <= cfg_data_i[15:0];
        fcce_pkg::CFG_SECTORS_PER_CLUSTER: spc_q   <= cfg_data_i[7:0];
        fcce_pkg::CFG_DATA_START_SECTOR:   dss_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      fcce_pkg::AS_SCAN: addr = scan_q[fcce_pkg::TBL_AW-1:0];
      default:           addr = clu_q[fcce_pkg::TBL_AW-1:0];
    endcase
    unique case (cmd_i.wd_sel)
      fcce_pkg::WD_WORD: wdata = word_q;
      fcce_pkg::WD_EOC:  wdata = fcce_pkg::EOC_WORD;
      fcce_pkg::WD_SCAN: wdata = 32'(scan_q);
      default:           wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[addr] <= wdata;
    if (cmd_i.mem_re) rdata_q <= mem_q[addr];
  end

  assign entry = rdata_q[27:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= item_i.operation;
      clu_q   <= item_i.cluster;
      word_q  <= item_i.word;
      steps_q <= '0;
      res_q   <= '0;
      rword_q <= '0;
      sect_q  <= '0;
      stat_q  <= fcce_pkg::ST_OK;
    end else begin
      if (cmd_i.free_adv) begin
        clu_q   <= entry;
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.res_from_entry) res_q <= entry;
      if (cmd_i.res_from_scan)  res_q <= 28'(scan_q);
      if (cmd_i.rword_load)     rword_q <= rdata_q;
      if (cmd_i.stat_we)        stat_q <= cmd_i.stat_val;
      if (cmd_i.add_en)         sect_q <= dss_q + prod_q;
    end
    if (cmd_i.scan_init) begin
      scan_q <= fcce_pkg::SCAN_W'(fcce_pkg::FIRST_CLUSTER);
    end else if (cmd_i.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ({4'b0, res_q} - 32'd2) * {24'b0, spc_q};
    end
  end

  always_comb begin
    sts_o.op            = fcce_pkg::op_e'(op_q);
    sts_o.clu_in_table  = (clu_q < 28'(fcce_pkg::TABLE_DEPTH));
    sts_o.clu_in_range  = fcce_pkg::in_range(clu_q, count_q);
    sts_o.entry_eoc     = (entry >= fcce_pkg::EOC_MARK);
    sts_o.entry_free    = (entry == '0);
    sts_o.scan_in_range = fcce_pkg::in_range(28'(scan_q), count_q);
    sts_o.free_more     = (entry < fcce_pkg::EOC_MARK) &&
                          fcce_pkg::in_range(entry, count_q) &&
                          (steps_q != fcce_pkg::TBL_AW'(fcce_pkg::TABLE_DEPTH - 1));
  end

  assign result_o.result_cluster = res_q;
  assign result_o.read_word      = rword_q;
  assign result_o.sector_address = sect_q;
  assign result_o.status         = stat_q;

endmodule

// File: src/fat32_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine
// In-memory FAT32 allocation table with load, read, next, allocate, extend
// and free-chain operations; each command returns one result beat.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start & !busy        item_i     (operation, cluster, word)
//  result    done_o, one cycle    result_o   (cluster, word, sector, status)
//  config    cfg_we_i             cfg_index_i, cfg_data_i
//
//  Allocate and extend of a chain end scan the table one entry at a time, and
//  free chain reads and clears one link at a time, all over the single table
//  port. busy stays high through the result cycle.
//  Reset clears the controller and configuration; the table holds no reset.
//  result_o holds until the next command is accepted; done_o lasts one cycle.
// ----------------------------------------------------------------------------
`include "fat32_cluster_chain_engine_macros.svh"

module fat32_cluster_chain_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fcce_pkg::item_t   item_i,
  output logic              done_o,
  output fcce_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  fcce_pkg::cmd_t cmd;
  fcce_pkg::sts_t sts;

  fcce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  fcce_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

  `FCCE_ASSERT_IMP(done_in_busy_a, clk_i, rst_ni, done_o, busy, "result beat while idle")
  `FCCE_ASSERT_NXT(done_then_idle_a, clk_i, rst_ni, done_o, !busy, "busy after result beat")
  `FCCE_ASSERT_NXT(start_takes_a, clk_i, rst_ni, start && !busy, busy && !done_o, "command not taken")
  `FCCE_ASSERT_IMP(fail_no_payload_a, clk_i, rst_ni, done_o && (result_o.status != fcce_pkg::ST_OK), (result_o.sector_address == 32'd0) && (result_o.result_cluster == 28'd0), "payload on failed result")

endmodule
